// ===== rtl/whacc_pkg.sv =====
// ----------------------------------------------------------------------------
// whacc_pkg
// Shared types and codes for the weighted histogram accumulator.
// ----------------------------------------------------------------------------
package whacc_pkg;

  // Operation codes carried in the input beat.
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SET   = 3'd2;
  localparam logic [2:0] OP_GET   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // Region codes.
  localparam logic [1:0] REG_BIN   = 2'd0;
  localparam logic [1:0] REG_UNDER = 2'd1;
  localparam logic [1:0] REG_OVER  = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_BINS_IN_USE = 1'b0;
  localparam logic [6:0] BINS_RESET = 7'd64;

  // Saturation limits.
  localparam logic signed [63:0] WS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] WS_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [62:0] SQ_MAX = '1;
  localparam logic [31:0] CNT_MAX = '1;

  // Width of (w*w)>>16 for a 32-bit signed weight.
  localparam int unsigned SQ_W = 47;

  typedef struct packed {
    logic [2:0]          operation;
    logic signed [31:0]  coordinate;
    logic signed [31:0]  weight;
    logic [6:0]          boundary_slot;
  } whacc_in_t;

  typedef struct packed {
    logic                in_range;
    logic [1:0]          region;
    logic [5:0]          bin_number;
    logic signed [63:0]  weight_sum;
    logic [62:0]         square_sum;
    logic [31:0]         entry_count;
  } whacc_out_t;

  // One accumulator entry: weight sum, squared weight sum, count.
  typedef struct packed {
    logic signed [63:0]  ws;
    logic [62:0]         ss;
    logic [31:0]         cnt;
  } acc_entry_t;

  // Search status toward the sequencer.
  typedef struct packed {
    logic        done;
    logic [1:0]  region;
  } srch_stat_t;

  // Commands from the sequencer to the accumulator store.
  typedef struct packed {
    logic        rd_en;
    logic        upd_en;
    logic [2:0]  op;
    logic [1:0]  region;
  } acc_cmd_t;

endpackage

// ===== rtl/whacc_search.sv =====
// ----------------------------------------------------------------------------
// whacc_search
// Boundary memory and iterative binary search, one read and compare a cycle.
// ----------------------------------------------------------------------------
module whacc_search #(
  parameter int unsigned MAX_BINS = 64,
  parameter int unsigned BW       = 7,
  parameter int unsigned BIN_W    = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [31:0]      x,
  input  logic [BW-1:0]           n,
  input  logic                    wr_en,
  input  logic [BW-1:0]           wr_addr,
  input  logic signed [31:0]      wr_data,
  output whacc_pkg::srch_stat_t   stat,
  output logic [BIN_W-1:0]        bin
);
  import whacc_pkg::*;

  typedef enum logic [3:0] {
    SR_IDLE = 4'b0001,
    SR_LOW  = 4'b0010,
    SR_HIGH = 4'b0100,
    SR_BIN  = 4'b1000
  } srch_state_t;

  srch_state_t state_r, state_nxt;

  logic signed [31:0] bnd_mem [MAX_BINS+1];
  logic signed [31:0] rdata_r;
  logic [BW-1:0]      raddr;

  logic signed [31:0] x_r;
  logic [BW-1:0]      n_r;
  logic [BW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [BW-1:0]      lo_new, hi_new, mid_new;
  logic [BW:0]        mid_sum;
  logic               gt;
  logic               fin;
  logic [1:0]         fin_region;
  logic [BW-1:0]      fin_bin;
  logic               done_r;
  logic [1:0]         region_r;
  logic [BIN_W-1:0]   bin_r;

  assign gt = x_r > rdata_r;

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    raddr      = '0;
    fin        = 1'b0;
    fin_region = REG_BIN;
    fin_bin    = '0;
    lo_new     = gt ? mid_r : lo_r;
    hi_new     = gt ? hi_r : mid_r;
    mid_sum    = {1'b0, lo_new} + {1'b0, hi_new};
    mid_new    = mid_sum[BW:1];
    unique case (state_r)
      SR_IDLE: begin
        if (start) begin
          state_nxt = SR_LOW;
        end
      end
      SR_LOW: begin
        if (!gt) begin
          fin        = 1'b1;
          fin_region = REG_UNDER;
        end else begin
          raddr     = n_r;
          state_nxt = SR_HIGH;
        end
      end
      SR_HIGH: begin
        if (gt) begin
          fin        = 1'b1;
          fin_region = REG_OVER;
        end else if (n_r > BW'(1)) begin
          lo_nxt    = '0;
          hi_nxt    = n_r;
          mid_nxt   = n_r >> 1;
          raddr     = n_r >> 1;
          state_nxt = SR_BIN;
        end else begin
          fin = 1'b1;
        end
      end
      SR_BIN: begin
        lo_nxt = lo_new;
        hi_nxt = hi_new;
        if (hi_new - lo_new > BW'(1)) begin
          mid_nxt = mid_new;
          raddr   = mid_new;
        end else begin
          fin     = 1'b1;
          fin_bin = lo_new;
        end
      end
      default: state_nxt = SR_IDLE;
    endcase
    if (fin) begin
      state_nxt = SR_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bnd_mem[wr_addr] <= wr_data;
    end
    rdata_r <= bnd_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      n_r <= n;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (fin) begin
      region_r <= fin_region;
      bin_r    <= fin_bin[BIN_W-1:0];
    end
  end

  assign stat.done   = done_r;
  assign stat.region = region_r;
  assign bin         = bin_r;

endmodule

// ===== rtl/whacc_accum.sv =====
// ----------------------------------------------------------------------------
// whacc_accum
// Accumulator store with saturating read-modify-write update.
// ----------------------------------------------------------------------------
module whacc_accum #(
  parameter int unsigned MAX_BINS = 64,
  parameter int unsigned BIN_W    = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  whacc_pkg::acc_cmd_t    cmd,
  input  logic [BIN_W-1:0]       bin,
  input  logic signed [31:0]     weight,
  output whacc_pkg::acc_entry_t  res
);
  import whacc_pkg::*;

  acc_entry_t          acc_mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld_r;
  acc_entry_t          rd_data_r;
  logic                rd_vld_r;
  acc_entry_t          under_r, over_r;
  acc_entry_t          cur, nxt;

  logic [31:0]         mag;
  logic [63:0]         prod;
  logic [SQ_W-1:0]     sq_r;
  logic [64:0]         ws_sum;
  logic [63:0]         ss_sum;
  logic [32:0]         cnt_sum;
  logic                is_set_bin;
  logic                wr_any;
  logic                clr;

  // Square of the held weight; it settles long before the update cycle.
  assign mag  = weight[31] ? 32'(-weight) : 32'(weight);
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    sq_r <= prod[SQ_W+15:16];
  end

  always_comb begin
    unique case (cmd.region)
      REG_UNDER: cur = under_r;
      REG_OVER:  cur = over_r;
      default:   cur = rd_vld_r ? rd_data_r : '0;
    endcase
  end

  assign ws_sum  = {cur.ws[63], cur.ws} + {{33{weight[31]}}, weight};
  assign ss_sum  = {1'b0, cur.ss} + 64'(sq_r);
  assign cnt_sum = {1'b0, cur.cnt} + 33'd1;
  assign is_set_bin = (cmd.op == OP_SET) && (cmd.region == REG_BIN);

  always_comb begin
    nxt = cur;
    if (cmd.op == OP_ADD) begin
      if (ws_sum[64] != ws_sum[63]) begin
        nxt.ws = ws_sum[64] ? WS_MIN : WS_MAX;
      end else begin
        nxt.ws = ws_sum[63:0];
      end
      nxt.ss  = ss_sum[63] ? SQ_MAX : ss_sum[62:0];
      nxt.cnt = cnt_sum[32] ? CNT_MAX : cnt_sum[31:0];
    end else if (is_set_bin) begin
      nxt.ws  = {{32{weight[31]}}, weight};
      nxt.ss  = 63'(sq_r);
      nxt.cnt = 32'd1;
    end
  end

  assign wr_any = cmd.upd_en && ((cmd.op == OP_ADD) || is_set_bin);
  assign clr    = cmd.upd_en && (cmd.op == OP_CLEAR);
  assign res    = nxt;

  always_ff @(posedge clk) begin
    if (wr_any && (cmd.region == REG_BIN)) begin
      acc_mem[bin] <= nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= acc_mem[bin];
      rd_vld_r  <= vld_r[bin];
    end
  end

  // A bin that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r   <= '0;
      under_r <= '0;
      over_r  <= '0;
    end else if (wr_any) begin
      unique case (cmd.region)
        REG_UNDER: under_r <= nxt;
        REG_OVER:  over_r  <= nxt;
        default:   vld_r[bin] <= 1'b1;
      endcase
    end
  end

endmodule

// ===== rtl/weighted_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator
// Add, set or get: lower edge check, upper edge check, then, with more than
// one bin in use, a binary search doing one boundary read a cycle; load, clear
// and unknown codes go straight to the update. The next item is taken in the
// cycle after the result is registered.
// Synchronous active-low reset clears control and all accumulators.
// ----------------------------------------------------------------------------
module weighted_histogram_accumulator #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  whacc_pkg::whacc_in_t              in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output whacc_pkg::whacc_out_t             out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [whacc_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import whacc_pkg::*;

  localparam int unsigned BW    = $clog2(MAX_BINS + 1);
  localparam int unsigned BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } seq_state_t;

  seq_state_t     state_r, state_nxt;
  whacc_in_t      item_r;
  whacc_out_t     out_r, out_nxt;
  logic           out_valid_r;
  logic [6:0]     bins_r;

  logic           accept;
  logic           is_lookup;
  logic           out_free;
  logic           cfg_wr;
  logic [BW+6:0]  bins_ext;
  logic [BW-1:0]  n_sel;
  logic [BW+6:0]  slot_ext;
  logic           bnd_wr;
  logic           item_lookup;

  srch_stat_t     srch_stat;
  logic [BIN_W-1:0] srch_bin;
  logic [BIN_W+5:0] bin_ext;
  acc_cmd_t       acc_cmd;
  acc_entry_t     acc_res;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= BINS_RESET;
    end else if (cfg_wr && (paddr[CFG_AW-1:2] == REG_BINS_IN_USE)) begin
      bins_r <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[CFG_AW-1:2] == REG_BINS_IN_USE) ? {25'd0, bins_r} : 32'd0;

  // Zero bins act as one, too many act as the maximum.
  assign bins_ext = {{BW{1'b0}}, bins_r};
  always_comb begin
    if (bins_r == 7'd0) begin
      n_sel = BW'(1);
    end else if (bins_ext > (BW + 7)'(MAX_BINS)) begin
      n_sel = BW'(MAX_BINS);
    end else begin
      n_sel = bins_ext[BW-1:0];
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_lookup = (in_item.operation == OP_ADD) || (in_item.operation == OP_SET) ||
                     (in_item.operation == OP_GET);
  assign out_free  = !out_valid_r || out_ready;

  assign slot_ext = {{BW{1'b0}}, in_item.boundary_slot};
  assign bnd_wr   = accept && (in_item.operation == OP_LOAD) &&
                    (slot_ext <= (BW + 7)'(MAX_BINS));

  whacc_search #(
    .MAX_BINS (MAX_BINS),
    .BW       (BW),
    .BIN_W    (BIN_W)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && is_lookup),
    .x       (in_item.coordinate),
    .n       (n_sel),
    .wr_en   (bnd_wr),
    .wr_addr (slot_ext[BW-1:0]),
    .wr_data (in_item.coordinate),
    .stat    (srch_stat),
    .bin     (srch_bin)
  );

  assign acc_cmd.rd_en  = (state_r == ST_SEARCH) && srch_stat.done;
  assign acc_cmd.upd_en = (state_r == ST_UPDATE) && out_free;
  assign acc_cmd.op     = item_r.operation;
  assign acc_cmd.region = srch_stat.region;

  whacc_accum #(
    .MAX_BINS (MAX_BINS),
    .BIN_W    (BIN_W)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (acc_cmd),
    .bin    (srch_bin),
    .weight (item_r.weight),
    .res    (acc_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = is_lookup ? ST_SEARCH : ST_UPDATE;
        end
      end
      ST_SEARCH: begin
        if (srch_stat.done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load, clear and unknown codes give an all-zero result beat.
  assign item_lookup = (item_r.operation == OP_ADD) || (item_r.operation == OP_SET) ||
                       (item_r.operation == OP_GET);
  assign bin_ext     = {6'd0, srch_bin};

  always_comb begin
    out_nxt = '0;
    if (item_lookup) begin
      out_nxt.in_range    = (srch_stat.region == REG_BIN);
      out_nxt.region      = srch_stat.region;
      out_nxt.bin_number  = (srch_stat.region == REG_BIN) ? bin_ext[5:0] : 6'd0;
      out_nxt.weight_sum  = acc_res.ws;
      out_nxt.square_sum  = acc_res.ss;
      out_nxt.entry_count = acc_res.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_cmd.upd_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (acc_cmd.upd_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/whacc_checker.sv =====
// ----------------------------------------------------------------------------
// whacc_checker
// Port-level checks on the weighted histogram accumulator.
// ----------------------------------------------------------------------------
module whacc_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  whacc_pkg::whacc_out_t             out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [whacc_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  input  logic [31:0]                       prdata,
  input  logic                              pready
);
  import whacc_pkg::*;

  // Coming out of reset the block is idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // One item at a time: an accepted beat drops ready.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A new result beat only appears while an item is being worked on.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without an item in flight");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // A register write reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == REG_BINS_IN_USE)
    |=> (paddr[CFG_AW-1:2] != REG_BINS_IN_USE) || (prdata[6:0] == $past(pwdata[6:0])))
    else $error("bins_in_use read back mismatch");

endmodule

bind weighted_histogram_accumulator whacc_checker u_whacc_checker (.*);

// ===== test/weighted_histogram_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_tb
// Self-checking bench for the weighted histogram accumulator. A directed run
// on four bins covers the field extremes, every operation and the corner
// cases. Random phases then sweep the bins-in-use register over its extremes
// on ascending and scrambled boundary sets, with random idling on both sides in some phases.
// A built-in predictor checks every result beat field by field.
// ----------------------------------------------------------------------------
module weighted_histogram_accumulator_tb;
  import whacc_pkg::*;

  localparam int NUM_BOUNDS       = 65;
  localparam int NUM_BINS         = 64;
  localparam int UNDER_IDX        = 64;
  localparam int OVER_IDX         = 65;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 65;
  localparam int MAX_REPORTS      = 50;

  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  localparam logic [CFG_AW-1:0] BINS_ADDR = {REG_BINS_IN_USE, 2'b00};

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  whacc_in_t         in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  whacc_out_t        out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor state.
  logic signed [31:0] bnd [NUM_BOUNDS];
  acc_entry_t         acc [NUM_BINS + 2];
  logic [6:0]         bins_cfg;

  whacc_in_t  stimulus_q[$];
  whacc_out_t expected_results[$];

  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int stuck_cycles = 0;
  int mismatches   = 0;
  bit drv_idle_en       = 1'b1;
  bit mon_idle_en       = 1'b1;
  bit long_hold_pending = 1'b0;

  weighted_histogram_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  function automatic int active_bins();
    if (bins_cfg == 0) begin
      return 1;
    end
    if (bins_cfg > NUM_BINS) begin
      return NUM_BINS;
    end
    return int'(bins_cfg);
  endfunction

  function automatic logic [62:0] square_q16(logic signed [31:0] w);
    logic signed [63:0] w64;
    logic [63:0] mag;
    logic [63:0] prod;
    w64 = w;
    mag = (w64 < 0) ? -w64 : w64;
    prod = (mag * mag) >> 16;
    return prod[62:0];
  endfunction

  // Same fixed search as the block: lower edge exclusive, upper edge inclusive.
  function automatic void locate_bin(input logic signed [31:0] x,
                                     output logic [1:0] region, output int bin);
    int n;
    int lo;
    int hi;
    int mid;
    n = active_bins();
    bin = 0;
    if (x <= bnd[0]) begin
      region = REG_UNDER;
    end else if (x > bnd[n]) begin
      region = REG_OVER;
    end else begin
      region = REG_BIN;
      lo = 0;
      hi = n;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (x > bnd[mid]) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      bin = lo;
    end
  endfunction

  function automatic whacc_out_t predict_histogram(whacc_in_t it);
    whacc_out_t res;
    logic [1:0] region;
    int bin;
    int idx;
    logic [64:0] wsum;
    logic [63:0] ssum;
    logic [62:0] sq;
    res = '0;
    case (it.operation)
      OP_LOAD: begin
        if (it.boundary_slot < NUM_BOUNDS) begin
          bnd[it.boundary_slot] = it.coordinate;
        end
      end
      OP_CLEAR: begin
        foreach (acc[i]) begin
          acc[i] = '0;
        end
      end
      OP_ADD, OP_SET, OP_GET: begin
        locate_bin(it.coordinate, region, bin);
        idx = (region == REG_UNDER) ? UNDER_IDX : (region == REG_OVER) ? OVER_IDX : bin;
        sq = square_q16(it.weight);
        if (it.operation == OP_ADD) begin
          wsum = {acc[idx].ws[63], acc[idx].ws} + {{33{it.weight[31]}}, it.weight};
          if (wsum[64] != wsum[63]) begin
            acc[idx].ws = wsum[64] ? WS_MIN : WS_MAX;
          end else begin
            acc[idx].ws = wsum[63:0];
          end
          ssum = {1'b0, acc[idx].ss} + {1'b0, sq};
          acc[idx].ss = ssum[63] ? SQ_MAX : ssum[62:0];
          if (acc[idx].cnt != CNT_MAX) begin
            acc[idx].cnt = acc[idx].cnt + 1;
          end
        end else if (it.operation == OP_SET && region == REG_BIN) begin
          acc[idx].ws = {{32{it.weight[31]}}, it.weight};
          acc[idx].ss = sq;
          acc[idx].cnt = 32'd1;
        end
        res.in_range = (region == REG_BIN);
        res.region = region;
        res.bin_number = bin[5:0];
        res.weight_sum = acc[idx].ws;
        res.square_sum = acc[idx].ss;
        res.entry_count = acc[idx].cnt;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic whacc_in_t random_item();
    whacc_in_t it;
    int r;
    int k;
    int jit;
    it.boundary_slot = 7'($urandom_range(0, 127));
    it.weight = $urandom();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.operation = OP_ADD;
    end else if (r < 59) begin
      it.operation = OP_GET;
    end else if (r < 71) begin
      it.operation = OP_SET;
    end else if (r < 88) begin
      it.operation = OP_LOAD;
      if ($urandom_range(0, 9) != 0) begin
        it.boundary_slot = 7'($urandom_range(0, NUM_BOUNDS - 1));
      end
    end else if (r < 91) begin
      it.operation = OP_CLEAR;
    end else begin
      it.operation = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    end
    // Most coordinates land within four of a boundary so both edges of a bin get hit.
    r = $urandom_range(0, 9);
    if (r == 0) begin
      it.coordinate = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    end else if (r <= 2) begin
      it.coordinate = $urandom();
    end else begin
      if (it.operation == OP_LOAD && it.boundary_slot < NUM_BOUNDS) begin
        k = it.boundary_slot;
      end else begin
        k = $urandom_range(0, active_bins());
      end
      jit = $urandom_range(0, 8);
      it.coordinate = bnd[k] + jit - 4;
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: it.weight = Q_MIN;
        1: it.weight = Q_MAX;
        2: it.weight = '0;
        default: it.weight = '1;
      endcase
    end else if (r > 4) begin
      jit = $urandom_range(0, 32'h7FFFF);
      it.weight = jit - 32'sh40000;
    end
    return it;
  endfunction

  task automatic push_item(input logic [2:0] op, input logic [31:0] x,
                           input logic [31:0] w, input logic [6:0] slot);
    whacc_in_t it;
    it.operation = op;
    it.coordinate = x;
    it.weight = w;
    it.boundary_slot = slot;
    stimulus_q.push_back(it);
  endtask

  // Loads all boundary slots, either as a rising ramp or scrambled.
  task automatic queue_boundaries(input bit ascending);
    longint v;
    v = longint'(Q_MIN) + $urandom_range(0, 1 << 24);
    for (int s = 0; s < NUM_BOUNDS; s++) begin
      if (ascending) begin
        push_item(OP_LOAD, v[31:0], $urandom(), s[6:0]);
        v = v + $urandom_range(0, 1 << 25);
      end else begin
        push_item(OP_LOAD, $urandom(), $urandom(), s[6:0]);
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (stimulus_q.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_bins_in_use(input logic [6:0] val);
    logic [31:0] noise;
    noise = $urandom();
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= BINS_ADDR;
    pwdata <= {noise[31:7], val};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bins_cfg = val;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : item_driver
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_histogram(in_item));
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stimulus_q.size() != 0) begin
          in_item <= stimulus_q.pop_front();
          offer = 1'b1;
          gap_left = drv_idle_en ? pick_gap() : 0;
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    whacc_out_t want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_item.weight_sum, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.in_range !== want.in_range)
            report_mismatch("in_range", 64'(out_item.in_range), 64'(want.in_range));
          if (out_item.region !== want.region)
            report_mismatch("region", 64'(out_item.region), 64'(want.region));
          if (out_item.bin_number !== want.bin_number)
            report_mismatch("bin_number", 64'(out_item.bin_number),
                            64'(want.bin_number));
          if (out_item.weight_sum !== want.weight_sum)
            report_mismatch("weight_sum", out_item.weight_sum, want.weight_sum);
          if (out_item.square_sum !== want.square_sum)
            report_mismatch("square_sum", 64'(out_item.square_sum),
                            64'(want.square_sum));
          if (out_item.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(out_item.entry_count),
                            64'(want.entry_count));
        end
      end
      // A long hold backs the block up while the sender keeps offering beats.
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (mon_idle_en && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [6:0] cfg_val;
    bins_cfg = BINS_RESET;
    foreach (bnd[i]) begin
      bnd[i] = '0;
    end
    foreach (acc[i]) begin
      acc[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on four bins: (-1, 0], (0, 1], (1, 2], (2, just below max].
    write_bins_in_use(7'd4);
    push_item(OP_LOAD, -Q_ONE, 32'd0, 7'd0);
    push_item(OP_LOAD, 32'd0, 32'd0, 7'd1);
    push_item(OP_LOAD, Q_ONE, 32'd0, 7'd2);
    push_item(OP_LOAD, 2 * Q_ONE, 32'd0, 7'd3);
    push_item(OP_LOAD, Q_MAX - 1, 32'd0, 7'd4);
    push_item(OP_LOAD, 32'h0000_1234, 32'hFFFF_FFFF, 7'd127);
    push_item(OP_ADD, Q_MIN, Q_MAX, 7'd0);
    push_item(OP_ADD, -Q_ONE, Q_MIN, 7'd127);
    push_item(OP_ADD, -Q_ONE + 1, Q_ONE, 7'd0);
    push_item(OP_ADD, 32'd0, 32'hFFFF_FFFF, 7'd0);
    push_item(OP_ADD, Q_MAX - 1, 32'h0000_8000, 7'd0);
    push_item(OP_ADD, Q_MAX, Q_MIN, 7'd0);
    push_item(OP_SET, 32'h0001_8000, Q_MAX, 7'd0);
    push_item(OP_SET, Q_MIN, 32'd5, 7'd0);
    push_item(OP_SET, Q_MAX, 32'd5, 7'd0);
    push_item(OP_GET, 32'd1, 32'd0, 7'd0);
    push_item(OP_GET, -Q_ONE + 1, 32'd0, 7'd0);
    push_item(OP_GET, Q_MAX, 32'd0, 7'd0);
    for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++) begin
      push_item(op[2:0], $urandom(), $urandom(), 7'($urandom_range(0, 127)));
    end
    push_item(OP_CLEAR, Q_MAX, Q_MAX, 7'd127);
    push_item(OP_GET, 32'd0, 32'd0, 7'd0);
    push_item(OP_GET, Q_MIN, 32'd0, 7'd0);
    wait_drained();

    // Every slot is written before any search can reach it.
    queue_boundaries(1'b1);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: cfg_val = 7'd64;
        1: cfg_val = 7'd1;
        2: cfg_val = 7'd0;
        3: cfg_val = 7'd127;
        4: cfg_val = 7'($urandom_range(2, 63));
        default: cfg_val = 7'($urandom_range(0, 127));
      endcase
      write_bins_in_use(cfg_val);
      if (p == 3) begin
        queue_boundaries(1'b0);
      end else if (p == 5) begin
        queue_boundaries(1'b1);
      end
      drv_idle_en = (p != 2 && p != 3);
      mon_idle_en = (p != 1 && p != 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        stimulus_q.push_back(random_item());
      end
      if (p == 0) begin
        long_hold_pending = 1'b1;
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
